// ===== hdl/rmez_pkg.sv =====
// rmez_pkg: shared constants and the cordic angle table for the
// rotation matrix to euler zyx unit. no dependencies.
`default_nettype none
package rmez_pkg;
  localparam int unsigned AngleTabLen = 24;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic [14:0] GimbalEps = 15'd16;
  // cordic datapath width: 16-bit operand scaled by 256 plus growth
  localparam int unsigned CW = 28;

  function automatic logic [31:0] angle_tab(input logic [4:0] idx);
    logic [31:0] r;
    begin
      unique case (idx)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10680350;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== hdl/rmez_cordic.sv =====
// rmez_cordic: pipelined vectoring cordic, atan2(y, x) as a 16-bit binary angle
// depends on rmez_pkg; one stage register per iteration, advanced by en_i
`default_nettype none
module rmez_cordic import rmez_pkg::*; #(
  parameter int unsigned Stages = 16
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  output logic             [15:0] ang_o
);
  logic signed [CW-1:0] x_q [Stages+1];
  logic signed [CW-1:0] y_q [Stages+1];
  logic        [31:0]   z_q [Stages+1];
  logic                 zero_q [Stages+1];

  // pre-rotation by pi for a negative x
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == 16'sd0) && (y_i == 16'sd0);
      if (x_i < 0) begin
        x_q[0] <= -($signed({{(CW-16){x_i[15]}}, x_i}) <<< 8);
        y_q[0] <= -($signed({{(CW-16){y_i[15]}}, y_i}) <<< 8);
        z_q[0] <= 32'h8000_0000;
      end else begin
        x_q[0] <= $signed({{(CW-16){x_i[15]}}, x_i}) <<< 8;
        y_q[0] <= $signed({{(CW-16){y_i[15]}}, y_i}) <<< 8;
        z_q[0] <= 32'd0;
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    logic        [31:0]   a;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign a  = (i < AngleTabLen) ? angle_tab(5'(i)) : 32'd0;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + a;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - a;
        end
      end
    end
  end

  logic [31:0] rnd;
  assign rnd   = z_q[Stages] + 32'h0000_8000;
  assign ang_o = zero_q[Stages] ? 16'd0 : rnd[31:16];
endmodule
`default_nettype wire

// ===== hdl/rmez_isqrt.sv =====
// rmez_isqrt: pipelined floor square root of a 29-bit value, one result bit a stage
// no package dependencies; advanced by en_i
`default_nettype none
module rmez_isqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [28:0] n_i,
  output logic      [14:0] root_o
);
  localparam int unsigned Bits = 15;
  logic [29:0] rem_q  [Bits];
  logic [14:0] root_q [Bits];

  for (genvar k = 0; k < Bits; k++) begin : g_bit
    localparam int unsigned B = Bits - 1 - k;
    logic [29:0] rem_in;
    logic [14:0] root_in;
    logic [29:0] trial;
    logic [14:0] cand;
    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, n_i};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end
    assign cand  = root_in | (15'd1 << B);
    assign trial = 30'(cand) * 30'(cand);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_in;
        root_q[k] <= (trial <= rem_in) ? cand : root_in;
      end
    end
  end

  assign root_o = root_q[Bits-1];
endmodule
`default_nettype wire

// ===== hdl/rotation_matrix_to_euler_zyx_unit.sv =====
// rotation_matrix_to_euler_zyx_unit: top level, handshake, delay lines, result register
// depends on rmez_pkg, rmez_cordic, rmez_isqrt
`default_nettype none
// Z-Y-X euler angles from five rotation matrix entries in signed Q1.14. one
// transaction is taken every cycle while the output is not stalled; the
// pitch path is the 15-stage square root feeding the pitch cordic of
// CORDIC_STAGES stages. yaw and roll cordics are delayed to line up. a stall
// on the output freezes the whole pipeline, no item is dropped.
module rotation_matrix_to_euler_zyx_unit import rmez_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // r00, r10, r20, r21, r22
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // yaw_angle, pitch_angle, roll_angle
  output logic             m_axis_tuser   // degenerate
);
  localparam int unsigned SqLat = 15;
  // square root, cordic input register, cordic stages, result register
  localparam int unsigned Lat = SqLat + CORDIC_STAGES + 2;

  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld_q[Lat-1];

  logic signed [15:0] r00, r10, r20, r21, r22, s;
  assign r00 = s_axis_tdata[15:0];
  assign r10 = s_axis_tdata[31:16];
  assign r20 = s_axis_tdata[47:32];
  assign r21 = s_axis_tdata[63:48];
  assign r22 = s_axis_tdata[79:64];
  assign s = (r20 > OneQ14) ? -OneQ14 : (r20 < -OneQ14) ? OneQ14 : -r20;

  // s and the raw entries wait for the square root
  logic signed [15:0] s_q [SqLat];
  logic signed [15:0] y0_q [SqLat], x0_q [SqLat], y2_q [SqLat], x2_q [SqLat];
  logic signed [31:0] s_w;
  logic [31:0] ssq;
  logic [28:0] arg;
  logic [14:0] c;
  assign s_w = 32'(s);
  assign ssq = $unsigned(s_w * s_w);
  assign arg = 29'(32'd268435456 - ssq);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0] <= s;
      y0_q[0] <= r10; x0_q[0] <= r00; y2_q[0] <= r21; x2_q[0] <= r22;
      for (int k = 1; k < SqLat; k++) begin
        s_q[k] <= s_q[k-1];
        y0_q[k] <= y0_q[k-1]; x0_q[k] <= x0_q[k-1];
        y2_q[k] <= y2_q[k-1]; x2_q[k] <= x2_q[k-1];
      end
    end
  end

  rmez_isqrt u_sqrt (.clk_i(clk_i), .en_i(en), .n_i(arg), .root_o(c));

  logic [CORDIC_STAGES:0] dg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dg_q <= {dg_q[CORDIC_STAGES-1:0], (c < GimbalEps)};
    end
  end

  logic [15:0] yaw, pitch, roll;
  rmez_cordic #(.Stages(CORDIC_STAGES)) u_yaw (.clk_i(clk_i), .en_i(en),
    .x_i(x0_q[SqLat-1]), .y_i(y0_q[SqLat-1]), .ang_o(yaw));
  rmez_cordic #(.Stages(CORDIC_STAGES)) u_pitch (.clk_i(clk_i), .en_i(en),
    .x_i($signed({1'b0, c})), .y_i(s_q[SqLat-1]), .ang_o(pitch));
  rmez_cordic #(.Stages(CORDIC_STAGES)) u_roll (.clk_i(clk_i), .en_i(en),
    .x_i(x2_q[SqLat-1]), .y_i(y2_q[SqLat-1]), .ang_o(roll));

  logic dg;
  assign dg = dg_q[CORDIC_STAGES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {dg ? 16'd0 : roll, pitch, yaw};
      m_axis_tuser <= dg;
    end
  end
endmodule
`default_nettype wire
